// File: design/nmea_sentence_deframer_top_macros.svh
// Assertion macros used by the deframer framer module (nsd_framer).
`ifndef NMEA_SENTENCE_DEFRAMER_TOP_MACROS_SVH
`define NMEA_SENTENCE_DEFRAMER_TOP_MACROS_SVH

// Same-cycle implication under an active-low reset.
`define NSD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under an active-low reset.
`define NSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/nsd_pkg.sv
// Package: types, character codes and decode functions of the NMEA deframer.
package nsd_pkg;

  localparam int unsigned MaxLenDefault = 128;

  localparam logic [7:0] ChrDollar = 8'h24;
  localparam logic [7:0] ChrStar   = 8'h2A;
  localparam logic [7:0] ChrCr     = 8'h0D;
  localparam logic [7:0] ChrLf     = 8'h0A;

  localparam logic [2:0] TypeGga     = 3'd0;
  localparam logic [2:0] TypeRmc     = 3'd1;
  localparam logic [2:0] TypeGsa     = 3'd2;
  localparam logic [2:0] TypeGsv     = 3'd3;
  localparam logic [2:0] TypeVtg     = 3'd4;
  localparam logic [2:0] TypeGll     = 3'd5;
  localparam logic [2:0] TypeZda     = 3'd6;
  localparam logic [2:0] TypeUnknown = 3'd7;

  localparam int unsigned NumTypes = 7;

  // Characters packed first-received in the low byte.
  localparam logic [NumTypes-1:0][23:0] TypeNames = '{
    {8'h41, 8'h44, 8'h5A},  // ZDA
    {8'h4C, 8'h4C, 8'h47},  // GLL
    {8'h47, 8'h54, 8'h56},  // VTG
    {8'h56, 8'h53, 8'h47},  // GSV
    {8'h41, 8'h53, 8'h47},  // GSA
    {8'h43, 8'h4D, 8'h52},  // RMC
    {8'h41, 8'h47, 8'h47}   // GGA
  };

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } nsd_stage_t;

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic       sentence_ok;
    logic [2:0] sentence_type;
    logic       checksum_mismatch;
    logic       overflow_drop;
  } nsd_result_t;

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      v = c[3:0];
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      v = 4'(c[2:0] + 3'd1) + 4'd8;
    end
    return v;
  endfunction

  function automatic logic [2:0] type_decode(input logic [23:0] chars);
    logic [2:0] t;
    t = TypeUnknown;
    for (int i = NumTypes - 1; i >= 0; i--) begin
      if (chars == TypeNames[i]) begin
        t = 3'(i);
      end
    end
    return t;
  endfunction

endpackage

// File: design/nsd_in_if.sv
// Interface: input character channel.
interface nsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

// File: design/nsd_out_if.sv
// Interface: result word channel.
interface nsd_out_if;
  logic       valid;
  logic       ready;
  logic       payload_valid;
  logic [7:0] payload_byte;
  logic       sentence_ok;
  logic [2:0] sentence_type;
  logic       checksum_mismatch;
  logic       overflow_drop;

  modport source (
    output valid, output payload_valid, output payload_byte, output sentence_ok,
    output sentence_type, output checksum_mismatch, output overflow_drop,
    input ready
  );
  modport sink (
    input valid, input payload_valid, input payload_byte, input sentence_ok,
    input sentence_type, input checksum_mismatch, input overflow_drop,
    output ready
  );
endinterface

// File: design/nmea_sentence_deframer_top.sv
// Top level: NMEA 0183 sentence deframer with XOR checksum check.
//
// Channels: in_i carries one received character per word (in_byte); out_o
// carries exactly one result word per accepted character: the payload byte
// pass-through, and on the second checksum digit the sentence type, a good
// flag and a mismatch flag; an overflow flag marks a dropped frame.
// Path: an accepted character is registered in the input register, then
// processed and written to the result register (two register stages).
// Throughput: one character per cycle while out_o.ready is high, set by the
// state update between the input register and the result register.
// Reset: the frame state returns to idle (waiting for '$'), the checksum,
// count and type bytes clear, and both stages empty.
// Stall: while out_o.ready is low the result word holds; the input register
// still takes one more character, then in_i.ready drops until the result
// is taken. No word is dropped or repeated.
module nmea_sentence_deframer_top #(
  parameter int unsigned MaxLen = nsd_pkg::MaxLenDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  nsd_in_if.sink           in_i,
  nsd_out_if.source        out_o
);

  nsd_pkg::nsd_stage_t  stage;
  nsd_pkg::nsd_result_t res;
  logic                 advance;
  logic                 res_valid;

  nsd_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_i.valid),
    .byte_i    (in_i.in_byte),
    .advance_i (advance),
    .ready_o   (in_i.ready),
    .stage_o   (stage)
  );

  nsd_framer #(
    .MaxLen (MaxLen)
  ) u_framer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stage_i     (stage),
    .out_ready_i (out_o.ready),
    .advance_o   (advance),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign out_o.valid             = res_valid;
  assign out_o.payload_valid     = res.payload_valid;
  assign out_o.payload_byte      = res.payload_byte;
  assign out_o.sentence_ok       = res.sentence_ok;
  assign out_o.sentence_type     = res.sentence_type;
  assign out_o.checksum_mismatch = res.checksum_mismatch;
  assign out_o.overflow_drop     = res.overflow_drop;

endmodule

// File: design/nsd_in_reg.sv
// Input register stage: holds one received character ahead of the framer.
module nsd_in_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [7:0]          byte_i,
  input  logic                advance_i,
  output logic                ready_o,
  output nsd_pkg::nsd_stage_t stage_o
);

  logic       valid_q, valid_d;
  logic [7:0] data_q, data_d;
  logic       load;

  assign ready_o = !valid_q || advance_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (load) begin
      valid_d = 1'b1;
      data_d  = byte_i;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign stage_o.valid = valid_q;
  assign stage_o.data  = data_q;

endmodule

// File: design/nsd_framer.sv
// Frame state, running checksum, type capture and result register.
`include "nmea_sentence_deframer_top_macros.svh"

module nsd_framer #(
  parameter int unsigned MaxLen = nsd_pkg::MaxLenDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  nsd_pkg::nsd_stage_t  stage_i,
  input  logic                 out_ready_i,
  output logic                 advance_o,
  output logic                 res_valid_o,
  output nsd_pkg::nsd_result_t res_o
);

  localparam int unsigned CntW = $clog2(MaxLen);
  localparam logic [CntW-1:0] CntLimit = CntW'(MaxLen - 1);

  typedef enum logic [1:0] {
    PhIdle,
    PhPayload,
    PhDigit1,
    PhDigit2
  } phase_e;

  phase_e               phase_q, phase_d;
  logic [CntW-1:0]      count_q, count_d;
  logic [7:0]           xor_q, xor_d;
  logic [3:0]           nib_q, nib_d;
  logic [2:0][7:0]      type_q, type_d;
  logic                 res_valid_q, res_valid_d;
  nsd_pkg::nsd_result_t res_q, res_d;
  logic                 take;
  logic [7:0]           c;
  logic [7:0]           rx_sum;

  assign advance_o = !res_valid_q || out_ready_i;
  assign take      = stage_i.valid && advance_o;
  assign c         = stage_i.data;
  assign rx_sum    = {nib_q, nsd_pkg::hex_value(c)};

  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    xor_d   = xor_q;
    nib_d   = nib_q;
    type_d  = type_q;
    res_d   = '0;
    res_d.sentence_type = nsd_pkg::TypeUnknown;
    case (phase_q)
      PhIdle: begin
        if (c == nsd_pkg::ChrDollar) begin
          phase_d = PhPayload;
          count_d = '0;
          xor_d   = '0;
          type_d  = '0;
        end
      end
      PhPayload: begin
        if (c == nsd_pkg::ChrStar) begin
          phase_d = PhDigit1;
        end else if (c == nsd_pkg::ChrCr || c == nsd_pkg::ChrLf) begin
          phase_d = PhIdle;
        end else if (count_q < CntLimit) begin
          for (int i = 0; i < 3; i++) begin
            if (count_q == CntW'(i + 3)) begin
              type_d[i] = c;
            end
          end
          count_d = count_q + 1'b1;
          xor_d   = xor_q ^ c;
          res_d.payload_valid = 1'b1;
          res_d.payload_byte  = c;
        end else begin
          res_d.overflow_drop = 1'b1;
          phase_d = PhIdle;
        end
      end
      PhDigit1: begin
        nib_d   = nsd_pkg::hex_value(c);
        phase_d = PhDigit2;
      end
      PhDigit2: begin
        if (count_q >= CntW'(6)) begin
          res_d.sentence_type = nsd_pkg::type_decode(type_q);
        end
        if (rx_sum == xor_q) begin
          res_d.sentence_ok = (res_d.sentence_type != nsd_pkg::TypeUnknown);
        end else begin
          res_d.checksum_mismatch = 1'b1;
        end
        phase_d = PhIdle;
      end
      default: begin
        phase_d = PhIdle;
      end
    endcase
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (take) begin
      res_valid_d = 1'b1;
    end else if (advance_o) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      count_q     <= '0;
      xor_q       <= '0;
      nib_q       <= '0;
      type_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      if (take) begin
        phase_q <= phase_d;
        count_q <= count_d;
        xor_q   <= xor_d;
        nib_q   <= nib_d;
        type_q  <= type_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  `NSD_ASSERT_NOW(a_end_goes_idle, clk_i, rst_ni,
    res_valid_q && (res_q.overflow_drop || res_q.sentence_ok || res_q.checksum_mismatch),
    phase_q == PhIdle, "frame end without return to idle")
  `NSD_ASSERT_NOW(a_ok_consistent, clk_i, rst_ni, res_valid_q && res_q.sentence_ok,
    !res_q.checksum_mismatch && res_q.sentence_type != nsd_pkg::TypeUnknown,
    "good sentence with mismatch or unknown type")
  `NSD_ASSERT_NOW(a_payload_counted, clk_i, rst_ni, res_valid_q && res_q.payload_valid,
    phase_q == PhPayload && count_q != '0, "payload byte without count advance")
  `NSD_ASSERT_NEXT(a_stall_holds_state, clk_i, rst_ni, res_valid_q && !out_ready_i,
    phase_q == $past(phase_q) && xor_q == $past(xor_q), "state moved while stalled")

endmodule

// File: tb/sv/nmea_sentence_deframer_top_tb.sv
// Testbench: NMEA sentence deframer, directed table then random sentences checked per word.
`timescale 1ns / 100ps

module nmea_sentence_deframer_top_tb;
  import nsd_pkg::*;

  localparam int unsigned FrameLimit = MaxLenDefault - 1;
  localparam int unsigned RandomChars = 650;
  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned MaxReports = 10;

  localparam nsd_result_t QuietWord = '{1'b0, 8'h00, 1'b0, TypeUnknown, 1'b0, 1'b0};
  localparam nsd_result_t GoodGga   = '{1'b0, 8'h00, 1'b1, TypeGga, 1'b0, 1'b0};
  localparam nsd_result_t BadSum    = '{1'b0, 8'h00, 1'b0, TypeUnknown, 1'b1, 1'b0};

  localparam logic [23:0] KnownNames [7] = '{"GGA", "RMC", "GSA", "GSV", "VTG", "GLL", "ZDA"};

  typedef enum logic [1:0] {PhIdle, PhPayload, PhDigitHi, PhDigitLo} frame_phase_e;
  typedef enum int {IdleNone, IdleSender, IdleReceiver, IdleBoth} idle_mode_e;

  typedef struct packed {
    logic [7:0]  chr;
    logic        typed;
    nsd_result_t want;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  nsd_in_if  in_ch ();
  nsd_out_if out_ch ();

  nmea_sentence_deframer_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  frame_phase_e phase_q    = PhIdle;
  int unsigned  count_q    = 0;
  logic [7:0]   sum_q      = 8'h00;
  logic [3:0]   nibble_q   = 4'h0;
  logic [7:0]   tchars_q [3] = '{8'h00, 8'h00, 8'h00};

  nsd_result_t  result_q [$];
  idle_mode_e   idle_mode;
  int unsigned  chars_sent  = 0;
  int unsigned  words_seen  = 0;
  int unsigned  fail_cnt    = 0;
  int unsigned  good_cnt    = 0;
  int unsigned  bad_cnt     = 0;
  int unsigned  drop_cnt    = 0;
  int unsigned  idle_cycles = 0;

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return 4'(c - "0");
    if (c >= "A" && c <= "F") return 4'(c - "A" + 8'd10);
    if (c >= "a" && c <= "f") return 4'(c - "a" + 8'd10);
    return 4'h0;
  endfunction

  function automatic logic [2:0] classify();
    if (count_q < 6) return TypeUnknown;
    case ({tchars_q[0], tchars_q[1], tchars_q[2]})
      "GGA":   return TypeGga;
      "RMC":   return TypeRmc;
      "GSA":   return TypeGsa;
      "GSV":   return TypeGsv;
      "VTG":   return TypeVtg;
      "GLL":   return TypeGll;
      "ZDA":   return TypeZda;
      default: return TypeUnknown;
    endcase
  endfunction

  function automatic nsd_result_t deframe_char(input logic [7:0] c);
    nsd_result_t r;
    logic [7:0]  rx_sum;
    r = '0;
    r.sentence_type = TypeUnknown;
    case (phase_q)
      PhIdle: begin
        if (c == ChrDollar) begin
          phase_q = PhPayload;
          count_q = 0;
          sum_q = 8'h00;
          tchars_q = '{8'h00, 8'h00, 8'h00};
        end
      end
      PhPayload: begin
        if (c == ChrStar) begin
          phase_q = PhDigitHi;
        end else if (c == ChrCr || c == ChrLf) begin
          phase_q = PhIdle;
        end else if (count_q < FrameLimit) begin
          if (count_q >= 3 && count_q <= 5) tchars_q[count_q-3] = c;
          count_q++;
          sum_q ^= c;
          r.payload_valid = 1'b1;
          r.payload_byte = c;
        end else begin
          r.overflow_drop = 1'b1;
          phase_q = PhIdle;
        end
      end
      PhDigitHi: begin
        nibble_q = nibble_of(c);
        phase_q = PhDigitLo;
      end
      default: begin
        rx_sum = {nibble_q, nibble_of(c)};
        r.sentence_type = classify();
        if (rx_sum == sum_q) begin
          r.sentence_ok = (r.sentence_type != TypeUnknown);
        end else begin
          r.checksum_mismatch = 1'b1;
        end
        phase_q = PhIdle;
      end
    endcase
    return r;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit lower);
    if (nib < 10) return "0" + 8'(nib);
    return (lower ? "a" : "A") + 8'(nib) - 8'd10;
  endfunction

  function automatic logic [7:0] field_char();
    logic [7:0] c;
    case ($urandom_range(0, 15))
      0: begin
        c = 8'($urandom_range(0, 255));
        while (c == ChrStar || c == ChrCr || c == ChrLf) c = 8'($urandom_range(0, 255));
      end
      1:       c = ChrDollar;
      2:       c = 8'h00;
      3:       c = ",";
      default: begin
        c = 8'($urandom_range(8'h20, 8'h7E));
        if (c == ChrStar) c = ".";
      end
    endcase
    return c;
  endfunction

  function automatic logic [7:0] upper_char();
    return 8'($urandom_range("A", "Z"));
  endfunction

  function automatic int unsigned send_idle_pct();
    case (idle_mode)
      IdleSender: return 53;
      IdleBoth:   return 13;
      default:    return 0;
    endcase
  endfunction

  function automatic int unsigned recv_stall_pct();
    case (idle_mode)
      IdleReceiver: return 53;
      IdleBoth:     return 13;
      default:      return 0;
    endcase
  endfunction

  task automatic send_char(input logic [7:0] c, input logic typed, input nsd_result_t want);
    nsd_result_t pred;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct()) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= c;
    do @(posedge clk_i); while (!in_ch.ready);
    pred = deframe_char(c);
    good_cnt += pred.sentence_ok;
    bad_cnt  += pred.checksum_mismatch;
    drop_cnt += pred.overflow_drop;
    result_q.push_back(typed ? want : pred);
    chars_sent++;
  endtask

  always @(negedge clk_i) begin
    out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct());
  end

  always @(posedge clk_i) begin
    nsd_result_t got;
    nsd_result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.payload_valid, out_ch.payload_byte, out_ch.sentence_ok,
              out_ch.sentence_type, out_ch.checksum_mismatch, out_ch.overflow_drop};
      if (result_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MaxReports) $display("unexpected result word %0d: %p", words_seen, got);
      end else begin
        want = result_q.pop_front();
        if (got !== want) begin
          fail_cnt++;
          if (fail_cnt <= MaxReports) begin
            $display("result word %0d: expected %p, actual %p", words_seen, want, got);
          end
        end
      end
      words_seen++;
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog: no word moved for %0d cycles", idle_cycles);
      $display("nmea_sentence_deframer_top: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    dir_row_t   dir_q [$];
    logic [7:0] frame_q [$];
    logic [7:0] ck;
    logic [7:0] c;
    int unsigned frame_idx;
    int unsigned kind;
    int unsigned len;
    bit         lower;

    rst_ni        = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = 8'h00;
    idle_mode     = IdleNone;

    dir_q = '{
      '{8'h00, 1'b1, QuietWord}, '{8'hFF, 1'b1, QuietWord}, '{ChrDollar, 1'b1, QuietWord},
      '{"G", 1'b0, QuietWord}, '{"P", 1'b0, QuietWord}, '{",", 1'b0, QuietWord},
      '{"G", 1'b0, QuietWord}, '{"G", 1'b0, QuietWord}, '{"A", 1'b0, QuietWord},
      '{ChrStar, 1'b1, QuietWord}, '{"7", 1'b0, QuietWord}, '{"A", 1'b1, GoodGga},
      '{ChrDollar, 1'b0, QuietWord}, '{"X", 1'b0, QuietWord}, '{ChrCr, 1'b1, QuietWord},
      '{ChrDollar, 1'b0, QuietWord}, '{ChrStar, 1'b1, QuietWord}, '{"G", 1'b0, QuietWord},
      '{"Z", 1'b1, QuietWord},
      '{ChrDollar, 1'b0, QuietWord}, '{8'h00, 1'b0, QuietWord}, '{ChrStar, 1'b0, QuietWord},
      '{"f", 1'b0, QuietWord}, '{"f", 1'b1, BadSum}
    };

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_q[i]) send_char(dir_q[i].chr, dir_q[i].typed, dir_q[i].want);

    frame_idx = 0;
    while (chars_sent < RandomChars + dir_q.size()) begin
      idle_mode = idle_mode_e'((frame_idx / 3) % 4);
      frame_q.delete();
      ck = 8'h00;
      kind = (frame_idx % 16 == 7) ? 99 : $urandom_range(0, 29);
      if (kind <= 1) begin
        len = $urandom_range(1, 6);
        repeat (len) frame_q.push_back(8'($urandom_range(0, 255)));
      end else if (kind <= 3) begin
        frame_q.push_back(ChrDollar);
        len = $urandom_range(0, 8);
        repeat (len) frame_q.push_back(field_char());
        frame_q.push_back($urandom_range(0, 1) ? ChrCr : ChrLf);
      end else begin
        frame_q.push_back(ChrDollar);
        if (kind == 99) begin
          len = $urandom_range(125, 129);
          repeat (len) begin
            c = field_char();
            ck ^= c;
            frame_q.push_back(c);
          end
        end else begin
          for (int k = 0; k < 3; k++) begin
            c = $urandom_range(0, 3) ? ((k == 0) ? "G" : "P") : upper_char();
            ck ^= c;
            frame_q.push_back(c);
          end
          case ($urandom_range(0, 9))
            7: len = $urandom_range(0, 3);
            8, 9: begin
              for (int k = 0; k < 3; k++) begin
                c = upper_char();
                ck ^= c;
                frame_q.push_back(c);
              end
              len = $urandom_range(0, 14);
            end
            default: begin
              for (int k = 2; k >= 0; k--) begin
                c = KnownNames[$urandom_range(0, 6)][8*k +: 8];
                ck ^= c;
                frame_q.push_back(c);
              end
              len = $urandom_range(0, 14);
            end
          endcase
          repeat (len) begin
            c = field_char();
            ck ^= c;
            frame_q.push_back(c);
          end
        end
        frame_q.push_back(ChrStar);
        lower = $urandom_range(0, 1);
        case ($urandom_range(0, 15))
          0: ck ^= 8'(1 << $urandom_range(0, 7));
          default: ;
        endcase
        frame_q.push_back(hex_char(ck[7:4], lower));
        frame_q.push_back(hex_char(ck[3:0], lower));
        if ($urandom_range(0, 15) == 1) begin
          case ($urandom_range(0, 3))
            0:       c = ChrCr;
            1:       c = ChrLf;
            2:       c = ChrDollar;
            default: c = "g";
          endcase
          frame_q[frame_q.size() - 1 - $urandom_range(0, 1)] = c;
        end
        if ($urandom_range(0, 1)) begin
          frame_q.push_back(ChrCr);
          frame_q.push_back(ChrLf);
        end
      end
      foreach (frame_q[i]) send_char(frame_q[i], 1'b0, QuietWord);
      frame_idx++;
    end

    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    idle_mode = IdleNone;
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (result_q.size() != 0) fail_cnt++;

    $display("sent %0d characters in %0d frames, checked %0d result words",
             chars_sent, frame_idx, words_seen);
    $display("sentences good %0d, checksum errors %0d, dropped frames %0d, failures %0d",
             good_cnt, bad_cnt, drop_cnt, fail_cnt);
    if (fail_cnt == 0) begin
      $display("nmea_sentence_deframer_top: match");
    end else begin
      $display("nmea_sentence_deframer_top: mismatch");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/nsd_pkg.sv
design/nsd_in_if.sv
design/nsd_out_if.sv
design/nsd_in_reg.sv
design/nsd_framer.sv
design/nmea_sentence_deframer_top.sv
tb/sv/nmea_sentence_deframer_top_tb.sv
